// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: command codes, field widths and the
// struct of step flags passed from the pointer control to the top level.
// Depends on nothing.
package deq_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    // Value reported for both ends while the queue is empty.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic wr_en;    // the step writes the store
        logic dropped;  // a push was refused because the queue is full
        logic empty;    // the queue is empty after the step
    } t_step_flags;

endpackage

// ===== rtl/deq_ifs.sv =====
// Valid/ready channel interfaces for the double-ended queue: the command
// channel and the result channel. Depends on deq_pkg.
interface deq_cmd_if
    import deq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_res_if
    import deq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
    logic                     push_dropped;

    modport source (output valid, output front_value, output back_value,
                    output is_empty, output occupancy, output push_dropped,
                    input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input is_empty, input occupancy, input push_dropped,
                    output ready);
endinterface

// ===== rtl/deq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable. Depends on nothing.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

// ===== rtl/deq_ctrl.sv =====
// Pointer control of the double-ended queue: front and back indices and the
// element count, with the write and read addresses of each step.
// Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [CMD_W-1:0]           i_command,
    output t_step_flags                o_flags,
    output logic [$clog2(DEPTH)-1:0]   o_wr_addr,
    output logic [$clog2(DEPTH)-1:0]   o_rd_front,
    output logic [$clog2(DEPTH)-1:0]   o_rd_back,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic          w_full;
    logic          w_wr_en;
    logic          w_dropped;
    logic [AW-1:0] w_wr_addr;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    assign w_full = (r_count == CW'(DEPTH));

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        w_wr_en   = 1'b0;
        w_dropped = 1'b0;
        w_wr_addr = r_back;
        case (i_command)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_dropped = 1'b1;
                end else begin
                    n_front   = slot_prev(r_front);
                    w_wr_addr = slot_prev(r_front);
                    w_wr_en   = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_dropped = 1'b1;
                end else begin
                    w_wr_addr = r_back;
                    n_back    = slot_next(r_back);
                    w_wr_en   = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (r_count != '0) begin
                    n_front = slot_next(r_front);
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (r_count != '0) begin
                    n_back  = slot_prev(r_back);
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    assign o_flags.wr_en   = w_wr_en;
    assign o_flags.dropped = w_dropped;
    assign o_flags.empty   = (n_count == '0);
    assign o_wr_addr       = w_wr_addr;
    assign o_rd_front      = n_front;
    assign o_rd_back       = slot_prev(n_back);
    assign o_count         = r_count;
endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on deq_pkg, deq_ifs, deq_ram and deq_ctrl.
//
// Usage:
// Commands arrive on the i_cmd channel: no operation, push at the front,
// push at the back, pop at the front or pop at the back, with the value to
// push. Every command transfer yields exactly one result transfer on o_res,
// in order, carrying the front and back values after the step (-1 when the
// queue is empty), the empty flag, the element count and a flag that is set
// when a push was refused because the queue was full. A pop on an empty
// queue changes nothing.
// The pointers and count move in the cycle the command is taken; the store
// is written and both ends are read in that same cycle, and a read that hits
// the entry being written takes the pushed value directly. The result is
// held in the read stage and then loaded into the output register, from
// which its own transfer is made. The block sustains one command per cycle
// while the receiver does not stall; the single read stage in the RAM ports
// sets the latency.
// When the receiver stalls, the result waits in the output register, the
// read stage holds its data, and i_cmd.ready falls once both are full.
// Reset empties the queue; store contents are only used after being written.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    deq_cmd_if.sink      i_cmd,
    deq_res_if.source    o_res
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_step_flags              w_flags;
    logic [AW-1:0]            w_wr_addr;
    logic [AW-1:0]            w_rd_front;
    logic [AW-1:0]            w_rd_back;
    logic [CW-1:0]            w_count;
    logic [CW+OCC_W-1:0]      w_count_ext;
    logic                     w_accept;
    logic                     w_out_load;
    logic                     w_wr_en;
    logic [DATA_W-1:0]        w_q_front;
    logic [DATA_W-1:0]        w_q_back;
    logic signed [DATA_W-1:0] w_front_value;
    logic signed [DATA_W-1:0] w_back_value;

    // Read stage: the RAM reads are in flight while these are held.
    logic                     r_s1_valid;
    logic                     r_s1_fwd_front;
    logic                     r_s1_fwd_back;
    logic signed [DATA_W-1:0] r_s1_value;
    logic                     r_s1_empty;
    logic                     r_s1_dropped;
    logic [OCC_W-1:0]         r_s1_occ;

    // Output register.
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_front;
    logic signed [DATA_W-1:0] r_out_back;
    logic                     r_out_empty;
    logic                     r_out_dropped;
    logic [OCC_W-1:0]         r_out_occ;

    // The read stage moves on only when the output register is free or
    // being emptied; a new command is taken only when the read stage is empty or moves.
    assign w_out_load   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready  = !r_s1_valid || w_out_load;
    assign w_accept     = i_cmd.valid && i_cmd.ready;
    assign w_wr_en      = w_accept && w_flags.wr_en;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_accept),
        .i_command  (i_cmd.command),
        .o_flags    (w_flags),
        .o_wr_addr  (w_wr_addr),
        .o_rd_front (w_rd_front),
        .o_rd_back  (w_rd_back),
        .o_count    (w_count)
    );

    // Two copies of the store, one for each end, so both ends are read in
    // the same cycle; both take every write.
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_front (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_cmd.push_value),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_front),
        .o_rd_data (w_q_front)
    );

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_back (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_cmd.push_value),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_back),
        .o_rd_data (w_q_back)
    );

    // The count after the step, masked to the width of the occupancy field.
    always_comb begin
        w_count_ext = {{OCC_W{1'b0}}, w_count};
        if (w_flags.wr_en) begin
            w_count_ext = w_count_ext + 1'b1;
        end else if (!w_flags.dropped && (w_count != '0)
                     && ((i_cmd.command == CMD_POP_FRONT)
                         || (i_cmd.command == CMD_POP_BACK))) begin
            w_count_ext = w_count_ext - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= w_accept;
        end
    end

    // A read of the entry written in the same cycle returns the old data,
    // so the pushed value is carried alongside and chosen instead.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_fwd_front <= w_wr_en && (w_wr_addr == w_rd_front);
            r_s1_fwd_back  <= w_wr_en && (w_wr_addr == w_rd_back);
            r_s1_value     <= i_cmd.push_value;
            r_s1_empty     <= w_flags.empty;
            r_s1_dropped   <= w_flags.dropped;
            r_s1_occ       <= w_count_ext[OCC_W-1:0];
        end
    end

    always_comb begin
        if (r_s1_empty) begin
            w_front_value = EMPTY_VALUE;
            w_back_value  = EMPTY_VALUE;
        end else begin
            w_front_value = r_s1_fwd_front ? r_s1_value : $signed(w_q_front);
            w_back_value  = r_s1_fwd_back  ? r_s1_value : $signed(w_q_back);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_front   <= w_front_value;
            r_out_back    <= w_back_value;
            r_out_empty   <= r_s1_empty;
            r_out_dropped <= r_s1_dropped;
            r_out_occ     <= r_s1_occ;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.front_value  = r_out_front;
    assign o_res.back_value   = r_out_back;
    assign o_res.is_empty     = r_out_empty;
    assign o_res.occupancy    = r_out_occ;
    assign o_res.push_dropped = r_out_dropped;

    // No command is taken while the read stage is held by a stalled output.
    a_no_accept_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_res.ready) |-> !w_accept)
        else $error("command taken while the read stage was held");

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(DEPTH))
        else $error("element count above depth");

    // A refused push leaves the count as it was and is flagged in the result.
    a_drop_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_flags.dropped) |=> ($stable(w_count) && r_s1_dropped))
        else $error("refused push changed the count or lost its flag");

    // A push that writes the store adds exactly one element.
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_flags.wr_en) |=> (w_count == $past(w_count) + 1'b1))
        else $error("accepted push did not add one element");
endmodule
